/* sv/fup_pkg.sv */
`default_nettype none
package fup_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [7:0] ALPHA_OFS = 8'h57;  // 'a' - 10

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } res_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    res_t [MAX_RESULTS-1:0]       res;
  } job_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] l;
    l = c;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      l = c + CASE_GAP;
    end
    return l - ALPHA_OFS;
  endfunction

  function automatic logic [7:0] plain_value(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage
`default_nettype wire

/* sv/fup_front.sv */
`default_nettype none
module fup_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire fup_pkg::in_t in_data_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output fup_pkg::job_t     q_job_o
);
  import fup_pkg::*;

  phase_e     phase_q, phase_d;
  esc_e       esc_q, esc_d;
  logic [7:0] fd_q, fd_d;
  logic       accept;
  logic [7:0] c;
  logic [7:0] dv_hi, dv_lo;
  logic [1:0] n;
  res_t [MAX_RESULTS-1:0] res;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_data_i.in_byte;
  assign dv_hi      = digit_value(fd_q);
  assign dv_lo      = digit_value(c);

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    fd_d    = fd_q;
    n       = 2'd0;
    res     = '0;

    if (phase_q == PH_VALUE) begin
      if (c == CH_AMP || c == CH_SEMI) begin
        if (esc_d == ESC_PCT) begin
          res[n] = '{KIND_VALUE, CH_PCT};
          n = n + 2'd1;
        end else if (esc_d == ESC_DIGIT) begin
          res[n] = '{KIND_VALUE, CH_PCT};
          n = n + 2'd1;
          res[n] = '{KIND_VALUE, plain_value(fd_d)};
          n = n + 2'd1;
        end
        esc_d = ESC_NONE;
        fd_d  = '0;
        res[n] = '{KIND_END, 8'h00};
        n = n + 2'd1;
        phase_d = PH_IDLE;
      end else begin
        case (esc_q)
          ESC_PCT: begin
            fd_d  = c;
            esc_d = ESC_DIGIT;
          end
          ESC_DIGIT: begin
            res[n] = '{KIND_VALUE, {dv_hi[3:0], 4'h0} + dv_lo};
            n = n + 2'd1;
            esc_d = ESC_NONE;
            fd_d  = '0;
          end
          default: begin
            if (c == CH_PCT) begin
              esc_d = ESC_PCT;
            end else begin
              res[n] = '{KIND_VALUE, plain_value(c)};
              n = n + 2'd1;
            end
          end
        endcase
      end
    end else begin
      if (c == CH_EQ) begin
        phase_d = PH_VALUE;
        esc_d   = ESC_NONE;
        fd_d    = '0;
      end else begin
        res[n] = '{KIND_KEY, c};
        n = n + 2'd1;
        phase_d = PH_KEY;
      end
    end

    if (in_data_i.end_of_string) begin
      if (phase_d == PH_VALUE) begin
        if (esc_d == ESC_PCT) begin
          res[n] = '{KIND_VALUE, CH_PCT};
          n = n + 2'd1;
        end else if (esc_d == ESC_DIGIT) begin
          res[n] = '{KIND_VALUE, CH_PCT};
          n = n + 2'd1;
          res[n] = '{KIND_VALUE, plain_value(fd_d)};
          n = n + 2'd1;
        end
        res[n] = '{KIND_END, 8'h00};
        n = n + 2'd1;
      end else if (phase_d == PH_KEY) begin
        res[n] = '{KIND_END, 8'h00};
        n = n + 2'd1;
      end
      phase_d = PH_IDLE;
      esc_d   = ESC_NONE;
      fd_d    = '0;
    end
  end

  assign q_push_o    = accept && (n != 2'd0);
  assign q_job_o.cnt = n;
  assign q_job_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      esc_q   <= ESC_NONE;
      fd_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      fd_q    <= fd_d;
    end
  end

endmodule
`default_nettype wire

/* sv/fup_queue.sv */
`default_nettype none
module fup_queue #(
  parameter int unsigned Depth = fup_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fup_pkg::job_t  push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output fup_pkg::job_t       head_o
);
  import fup_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

/* sv/fup_back.sv */
`default_nettype none
module fup_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire fup_pkg::job_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fup_pkg::out_t      out_data_o
);
  import fup_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       last;
  logic       fire;

  assign out_valid_o = !q_empty_i;
  assign last        = (idx_q == q_head_i.cnt - 2'd1);
  assign fire        = out_valid_o && out_ready_i;
  assign q_pop_o     = fire && last;

  assign out_data_o.kind        = q_head_i.res[idx_q].kind;
  assign out_data_o.out_byte    = q_head_i.res[idx_q].out_byte;
  assign out_data_o.last_of_run = last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

/* sv/form_urlencoded_pair_parser.sv */
// Form-urlencoded key/value splitter and decoder.
// Input channel: one byte of the encoded string per item (in_data_i), with
// end_of_string set on its last byte. Output channel: one result per item,
// a key byte, a decoded value byte or a pair-end marker; last_of_run marks
// the final result caused by one input byte (up to three per byte).
// The front decodes each input byte in the cycle it is accepted and writes
// all its results as one entry into a QueueDepth-entry queue; the back plays
// an entry out one result per cycle while out_ready_i is high. Bytes that
// cause no result ('=' outside a value, '%' and the first escape digit in
// a value) only update the front state. Throughput: one input byte per
// cycle while the queue has room; the output side sustains one result per
// cycle while out_ready_i is high, so bytes with two or three results set
// the long-run input rate to one byte per result delivered.
// Stall: with out_ready_i low, results wait in the queue; in_ready_o drops
// only once the queue is full.
// Reset: parser returns to between pairs with no escape pending and the
// queue empty.
`default_nettype none
module form_urlencoded_pair_parser #(
  parameter int unsigned QueueDepth = fup_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire fup_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output fup_pkg::out_t     out_data_o
);
  import fup_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  job_t push_job, head_job;

  fup_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  fup_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  fup_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
